/* rtl/tlik_pkg.sv */
// shared constants, types and codes of the two-link inverse kinematics pipeline
// no dependencies; imported by the interfaces and every module of the block

package tlik_pkg;

   localparam int COORD_WIDTH_DEF = 24;

   // link lengths and tolerance
   localparam int LEN_W  = 23;
   localparam int TOL_W  = 32;

   // geometry widths, fixed by the link length width
   localparam int MAG_W  = LEN_W + 1;      // |dx|, |dy|, l1+l2 after range check
   localparam int SQ_W   = 2 * MAG_W;      // squared distances
   localparam int HALF_W = SQ_W / 2;
   localparam int DISC_W = 2 * SQ_W;       // discriminant
   localparam int ROOT_W = SQ_W;           // floor sqrt of discriminant
   localparam int K_W    = SQ_W + 2;       // l1^2 - l2^2 + d2, signed
   localparam int KL_W   = 25;             // low slice of k for the split products
   localparam int KH_W   = K_W - KL_W;
   localparam int DXN_W  = MAG_W + 1;      // signed offset after range check
   localparam int NUM_W  = DXN_W + K_W + 3;
   localparam int BASE_W = 32;             // widest legal coordinate

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [LEN_W-1:0] UPPER_RESET = LEN_W'(4096);
   localparam logic [LEN_W-1:0] LOWER_RESET = LEN_W'(4096);
   localparam logic [TOL_W-1:0] TOL_RESET   = TOL_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UPPER = 2'd0,
      CSR_LOWER = 2'd1,
      CSR_TOL   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      COUNT_NONE = 2'd0,
      COUNT_ONE  = 2'd1,
      COUNT_TWO  = 2'd2
   } count_type;

   // per-item geometry that rides along the square root pipeline
   typedef struct packed {
      logic                     ok;
      logic                     tan;
      logic signed [DXN_W-1:0]  dx;
      logic signed [DXN_W-1:0]  dy;
      logic [MAG_W-1:0]         adx;
      logic [MAG_W-1:0]         ady;
      logic signed [K_W-1:0]    k;
      logic [SQ_W-1:0]          d2;
      logic signed [BASE_W-1:0] bx;
      logic signed [BASE_W-1:0] by;
   } geo_type;

endpackage

/* rtl/tlik_if.sv */
// request and response channel interfaces of the inverse kinematics block
// depends on tlik_pkg

interface tlik_req_if import tlik_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] base_x;
   logic signed [COORD_WIDTH-1:0] base_y;
   logic signed [COORD_WIDTH-1:0] target_x;
   logic signed [COORD_WIDTH-1:0] target_y;

   modport source (output valid, base_x, base_y, target_x, target_y, input ready);
   modport sink   (input valid, base_x, base_y, target_x, target_y, output ready);
endinterface

interface tlik_rsp_if import tlik_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic [1:0]                    solution_count;
   logic signed [COORD_WIDTH-1:0] elbow_a_x;
   logic signed [COORD_WIDTH-1:0] elbow_a_y;
   logic signed [COORD_WIDTH-1:0] elbow_b_x;
   logic signed [COORD_WIDTH-1:0] elbow_b_y;

   modport source (output valid, solution_count, elbow_a_x, elbow_a_y, elbow_b_x,
                   elbow_b_y, input ready);
   modport sink   (input valid, solution_count, elbow_a_x, elbow_a_y, elbow_b_x,
                   elbow_b_y, output ready);
endinterface

/* rtl/tlik_geom.sv */
// front end: offsets, range checks, squared distances, k and the discriminant
// seven register stages; depends on tlik_pkg

module tlik_geom import tlik_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic signed [COORD_WIDTH-1:0] base_x,
   input  logic signed [COORD_WIDTH-1:0] base_y,
   input  logic signed [COORD_WIDTH-1:0] target_x,
   input  logic signed [COORD_WIDTH-1:0] target_y,
   input  logic [LEN_W-1:0]              upper_len,
   input  logic [LEN_W-1:0]              lower_len,
   input  logic [TOL_W-1:0]              tolerance,
   output logic                          out_valid,
   output logic [DISC_W-1:0]             disc,
   output geo_type                       geo
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int AW = (DW > MAG_W) ? DW : MAG_W;

   // stage 0
   logic                          v0_ff;
   logic signed [DW-1:0]          dx0_ff, dy0_ff, dx_in, dy_in;
   logic signed [COORD_WIDTH-1:0] bx0_ff, by0_ff;
   // stage 1
   logic                          v1_ff, far1_ff, far_in;
   logic [DW-1:0]                 adx_in, ady_in;
   logic [MAG_W-1:0]              adx1_ff, ady1_ff, sum1_ff, diff1_ff, sum_in, diff_in;
   logic signed [DXN_W-1:0]       dx1_ff, dy1_ff;
   logic signed [BASE_W-1:0]      bx1_ff, by1_ff;
   // stage 2
   logic                          v2_ff, far2_ff;
   logic [SQ_W-1:0]               sqx2_ff, sqy2_ff, lo2_ff, hi2_ff, l1sq2_ff, l2sq2_ff;
   logic signed [DXN_W-1:0]       dx2_ff, dy2_ff;
   logic [MAG_W-1:0]              adx2_ff, ady2_ff;
   logic signed [BASE_W-1:0]      bx2_ff, by2_ff;
   // stage 3
   logic                          v3_ff;
   logic [SQ_W:0]                 d2_in;
   logic [SQ_W-1:0]               e1_3_ff, e2_3_ff;
   geo_type                       geo3_ff, geo3_in;
   // stage 4
   logic                          v4_ff;
   geo_type                       geo4_ff;
   logic [SQ_W-1:0]               pp_hh_ff, pp_hl_ff, pp_lh_ff, pp_ll_ff;
   // stage 5
   logic                          v5_ff;
   geo_type                       geo5_ff;
   logic [DISC_W-1:0]             disc5_ff;
   // stage 6
   logic                          v6_ff;
   geo_type                       geo6_ff, geo6_in;
   logic [DISC_W-1:0]             disc6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_comb begin
      dx_in   = DW'(target_x) - DW'(base_x);
      dy_in   = DW'(target_y) - DW'(base_y);
      adx_in  = dx0_ff[DW-1] ? DW'(-dx0_ff) : DW'(dx0_ff);
      ady_in  = dy0_ff[DW-1] ? DW'(-dy0_ff) : DW'(dy0_ff);
      sum_in  = MAG_W'(upper_len) + MAG_W'(lower_len);
      diff_in = (upper_len > lower_len) ? MAG_W'(upper_len - lower_len)
                                        : MAG_W'(lower_len - upper_len);
      far_in  = (AW'(adx_in) > AW'(sum_in)) || (AW'(ady_in) > AW'(sum_in));

      d2_in        = {1'b0, sqx2_ff} + {1'b0, sqy2_ff};
      geo3_in.ok   = !far2_ff && (d2_in != '0) && (d2_in >= {1'b0, lo2_ff})
                     && (d2_in <= {1'b0, hi2_ff});
      geo3_in.tan  = 1'b0;
      geo3_in.dx   = dx2_ff;
      geo3_in.dy   = dy2_ff;
      geo3_in.adx  = adx2_ff;
      geo3_in.ady  = ady2_ff;
      geo3_in.k    = K_W'(l1sq2_ff) - K_W'(l2sq2_ff) + K_W'(d2_in);
      geo3_in.d2   = d2_in[SQ_W-1:0];
      geo3_in.bx   = bx2_ff;
      geo3_in.by   = by2_ff;

      // tangent when the discriminant is below the tolerance
      geo6_in      = geo5_ff;
      geo6_in.tan  = disc5_ff < DISC_W'(tolerance);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx0_ff   <= dx_in;
         dy0_ff   <= dy_in;
         bx0_ff   <= base_x;
         by0_ff   <= base_y;

         adx1_ff  <= MAG_W'(adx_in);
         ady1_ff  <= MAG_W'(ady_in);
         sum1_ff  <= sum_in;
         diff1_ff <= diff_in;
         far1_ff  <= far_in;
         dx1_ff   <= DXN_W'(dx0_ff);
         dy1_ff   <= DXN_W'(dy0_ff);
         bx1_ff   <= BASE_W'(bx0_ff);
         by1_ff   <= BASE_W'(by0_ff);

         sqx2_ff  <= adx1_ff * adx1_ff;
         sqy2_ff  <= ady1_ff * ady1_ff;
         lo2_ff   <= diff1_ff * diff1_ff;
         hi2_ff   <= sum1_ff * sum1_ff;
         l1sq2_ff <= upper_len * upper_len;
         l2sq2_ff <= lower_len * lower_len;
         far2_ff  <= far1_ff;
         dx2_ff   <= dx1_ff;
         dy2_ff   <= dy1_ff;
         adx2_ff  <= adx1_ff;
         ady2_ff  <= ady1_ff;
         bx2_ff   <= bx1_ff;
         by2_ff   <= by1_ff;

         geo3_ff  <= geo3_in;
         e1_3_ff  <= SQ_W'(d2_in - {1'b0, lo2_ff});
         e2_3_ff  <= SQ_W'({1'b0, hi2_ff} - d2_in);

         // discriminant as four half-width partial products
         geo4_ff  <= geo3_ff;
         pp_hh_ff <= e1_3_ff[SQ_W-1:HALF_W] * e2_3_ff[SQ_W-1:HALF_W];
         pp_hl_ff <= e1_3_ff[SQ_W-1:HALF_W] * e2_3_ff[HALF_W-1:0];
         pp_lh_ff <= e1_3_ff[HALF_W-1:0] * e2_3_ff[SQ_W-1:HALF_W];
         pp_ll_ff <= e1_3_ff[HALF_W-1:0] * e2_3_ff[HALF_W-1:0];

         geo5_ff  <= geo4_ff;
         disc5_ff <= (DISC_W'(pp_hh_ff) << SQ_W) + (DISC_W'(pp_hl_ff) << HALF_W)
                     + (DISC_W'(pp_lh_ff) << HALF_W) + DISC_W'(pp_ll_ff);

         geo6_ff  <= geo6_in;
         disc6_ff <= disc5_ff;
      end
   end

   assign out_valid = v6_ff;
   assign disc      = disc6_ff;
   assign geo       = geo6_ff;

endmodule

/* rtl/tlik_sqrt.sv */
// pipelined integer square root, one root bit per register stage
// depends on tlik_pkg

module tlik_sqrt import tlik_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  logic [DISC_W-1:0] radicand,
   input  geo_type           geo_in,
   output logic              out_valid,
   output logic [ROOT_W-1:0] root,
   output geo_type           geo_out
);

   logic [DISC_W-1:0] rem_ff   [0:ROOT_W-1];
   logic [ROOT_W-1:0] root_ff  [0:ROOT_W-1];
   geo_type           geo_ff   [0:ROOT_W-1];
   logic              valid_ff [0:ROOT_W-1];

   logic [DISC_W-1:0] src_rem  [0:ROOT_W-1];
   logic [ROOT_W-1:0] src_root [0:ROOT_W-1];
   logic [DISC_W-1:0] trial    [0:ROOT_W-1];
   logic [DISC_W-1:0] rem_in   [0:ROOT_W-1];
   logic [ROOT_W-1:0] root_in  [0:ROOT_W-1];

   // stage s decides root bit ROOT_W-1-s; rem holds radicand minus root squared
   always_comb begin
      src_rem[0]  = radicand;
      src_root[0] = '0;
      for (int s = 1; s < ROOT_W; s++) begin
         src_rem[s]  = rem_ff[s-1];
         src_root[s] = root_ff[s-1];
      end
      for (int s = 0; s < ROOT_W; s++) begin
         trial[s] = (DISC_W'(src_root[s]) << (ROOT_W - s))
                    | (DISC_W'(1) << (2 * (ROOT_W - 1 - s)));
         if (src_rem[s] >= trial[s]) begin
            rem_in[s]  = src_rem[s] - trial[s];
            root_in[s] = src_root[s] | (ROOT_W'(1) << (ROOT_W - 1 - s));
         end else begin
            rem_in[s]  = src_rem[s];
            root_in[s] = src_root[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < ROOT_W; s++) valid_ff[s] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < ROOT_W; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         geo_ff[0] <= geo_in;
         for (int s = 1; s < ROOT_W; s++) geo_ff[s] <= geo_ff[s-1];
         for (int s = 0; s < ROOT_W; s++) begin
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];
   assign geo_out   = geo_ff[ROOT_W-1];

endmodule

/* rtl/tlik_div.sv */
// one coordinate lane: round-to-nearest division by 2*d2, base add, saturation
// restoring divider with one quotient bit per stage; depends on tlik_pkg

module tlik_div import tlik_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic signed [NUM_W-1:0]       num,
   input  logic [SQ_W-1:0]               d2,
   input  logic signed [COORD_WIDTH-1:0] base,
   input  count_type                     tag_in,
   output logic                          out_valid,
   output logic signed [COORD_WIDTH-1:0] coord,
   output count_type                     tag_out
);

   localparam int QB    = COORD_WIDTH + 1;
   localparam int DV_W  = SQ_W + 1;
   localparam int RW    = (NUM_W + 1 > DV_W + QB) ? NUM_W + 1 : DV_W + QB;
   localparam int SUM_W = COORD_WIDTH + 3;
   localparam int NST   = QB + 5;
   localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) << (COORD_WIDTH - 1)) - 1;
   localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - 1;

   logic                          valid_ff [0:NST-1];

   // front stages
   logic                          neg0_ff;
   logic [NUM_W-1:0]              mag0_ff;
   logic [SQ_W-1:0]               d2_0_ff;
   logic [RW-1:0]                 m1_ff;
   logic [DV_W-1:0]               dv1_ff;

   // divider stages, index 0 is the overflow check stage
   logic [RW-1:0]                 rem_ff  [0:QB];
   logic [QB-1:0]                 q_ff    [0:QB];
   logic [DV_W-1:0]               dv_ff   [0:QB];
   logic                          ovf_ff  [0:QB];
   logic                          neg_ff  [0:QB+1];
   logic signed [COORD_WIDTH-1:0] base_ff [0:QB+3];
   count_type                     tag_ff  [0:NST-1];

   logic [RW-1:0]                 test    [0:QB-1];
   logic [RW-1:0]                 rem_in  [0:QB-1];
   logic [QB-1:0]                 q_in    [0:QB-1];

   // tail stages
   logic signed [QB:0]            sv_ff, sv_in;
   logic [QB-1:0]                 qv;
   logic signed [SUM_W-1:0]       sum;
   logic signed [COORD_WIDTH-1:0] coord_ff, coord_in;

   always_comb begin
      for (int j = 0; j < QB; j++) begin
         test[j] = RW'(dv_ff[j]) << (QB - 1 - j);
         if (rem_ff[j] >= test[j]) begin
            rem_in[j] = rem_ff[j] - test[j];
            q_in[j]   = q_ff[j] | (QB'(1) << (QB - 1 - j));
         end else begin
            rem_in[j] = rem_ff[j];
            q_in[j]   = q_ff[j];
         end
      end
      // a quotient out of range saturates the coordinate either way
      qv    = ovf_ff[QB] ? '1 : q_ff[QB];
      sv_in = neg_ff[QB+1] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
      sum   = SUM_W'(base_ff[QB+3]) + SUM_W'(sv_ff);
      if (tag_ff[NST-2] == COUNT_NONE) begin
         coord_in = '0;
      end else if (sum > SAT_HI) begin
         coord_in = COORD_WIDTH'(SAT_HI);
      end else if (sum < SAT_LO) begin
         coord_in = COORD_WIDTH'(SAT_LO);
      end else begin
         coord_in = COORD_WIDTH'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NST; s++) valid_ff[s] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < NST; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff[0] <= tag_in;
         for (int s = 1; s < NST; s++) tag_ff[s] <= tag_ff[s-1];

         // magnitude and sign
         neg0_ff    <= num[NUM_W-1];
         mag0_ff    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         d2_0_ff    <= d2;
         base_ff[0] <= base;

         // add half the divisor for rounding
         m1_ff      <= RW'(mag0_ff) + RW'(d2_0_ff);
         dv1_ff     <= {d2_0_ff, 1'b0};
         neg_ff[0]  <= neg0_ff;
         base_ff[1] <= base_ff[0];

         // overflow check, then the quotient bits
         rem_ff[0]  <= m1_ff;
         q_ff[0]    <= '0;
         dv_ff[0]   <= dv1_ff;
         ovf_ff[0]  <= m1_ff >= (RW'(dv1_ff) << QB);
         neg_ff[1]  <= neg_ff[0];
         base_ff[2] <= base_ff[1];

         for (int j = 0; j < QB; j++) begin
            rem_ff[j+1]  <= rem_in[j];
            q_ff[j+1]    <= q_in[j];
            dv_ff[j+1]   <= dv_ff[j];
            ovf_ff[j+1]  <= ovf_ff[j];
            neg_ff[j+2]  <= neg_ff[j+1];
            base_ff[j+3] <= base_ff[j+2];
         end
         base_ff[QB+3] <= base_ff[QB+2];

         sv_ff    <= sv_in;
         coord_ff <= coord_in;
      end
   end

   assign out_valid = valid_ff[NST-1];
   assign coord     = coord_ff;
   assign tag_out   = tag_ff[NST-1];

endmodule

/* rtl/two_link_inverse_kinematics.sv */
// top level of the two-link planar arm inverse kinematics pipeline
// depends on tlik_pkg, tlik_if, tlik_geom, tlik_sqrt and tlik_div
//
// usage
//   req_if carries one item per base point and wrist target, rsp_if returns one
//   item with the solution count and two elbow points for every request item.
//   csr_we/csr_index/csr_data write the link lengths and the tangent tolerance;
//   write them only while no item is in flight.
// timing
//   fully pipelined: a new item is taken every cycle unless backpressure holds
//   the pipeline. it has 7 stages of geometry and discriminant, 48 square root
//   stages (one root bit each), 3 product stages and COORD_WIDTH + 6 stages in
//   the dividers, which produce one quotient bit per stage.
// reset
//   synchronous; clears all valid bits and loads the default link lengths
//   (1.0 each) and a tolerance of 1.
// backpressure
//   the whole pipeline holds while a result waits on rsp_if and rsp_if.ready is
//   low; req_if.ready drops in the same cycle, so nothing is lost or repeated.
//   if the receiver takes results as they come, req_if.ready stays high.

module two_link_inverse_kinematics import tlik_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tlik_req_if.sink              req_if,
   tlik_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [LEN_W-1:0] upper_ff, lower_ff;
   logic [TOL_W-1:0] tol_ff;
   logic             advance;

   // configuration registers, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= UPPER_RESET;
         lower_ff <= LOWER_RESET;
         tol_ff   <= TOL_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_UPPER: upper_ff <= csr_data[LEN_W-1:0];
            CSR_LOWER: lower_ff <= csr_data[LEN_W-1:0];
            CSR_TOL:   tol_ff   <= csr_data[TOL_W-1:0];
            default:   ;
         endcase
      end
   end

   // global pipeline enable: move when the output stage is empty or being taken
   assign advance      = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = advance;

   // geometry and discriminant
   logic              gm_valid;
   logic [DISC_W-1:0] gm_disc;
   geo_type           gm_geo;

   tlik_geom #(.COORD_WIDTH(COORD_WIDTH)) u_geom (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_if.valid),
      .base_x    (req_if.base_x),
      .base_y    (req_if.base_y),
      .target_x  (req_if.target_x),
      .target_y  (req_if.target_y),
      .upper_len (upper_ff),
      .lower_len (lower_ff),
      .tolerance (tol_ff),
      .out_valid (gm_valid),
      .disc      (gm_disc),
      .geo       (gm_geo)
   );

   // square root of the discriminant
   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   geo_type           sq_geo;

   tlik_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (gm_valid),
      .radicand  (gm_disc),
      .geo_in    (gm_geo),
      .out_valid (sq_valid),
      .root      (sq_root),
      .geo_out   (sq_geo)
   );

   // product stage 0: split products, a tangent takes a zero root
   logic [ROOT_W-1:0]                r_sel;
   logic                             p0_valid_ff, p1_valid_ff, p2_valid_ff;
   logic signed [DXN_W+KH_W-1:0]     pxh_ff, pyh_ff;
   logic signed [DXN_W+KL_W:0]       pxl_ff, pyl_ff;
   logic [MAG_W+HALF_W-1:0]          a2h_ff, a2l_ff, a4h_ff, a4l_ff;
   logic                             s4neg0_ff, s4neg1_ff;
   count_type                        cnt0_ff, cnt1_ff, cnt2_ff, cnt_in;
   logic [SQ_W-1:0]                  d2_0_ff, d2_1_ff, d2_2_ff;
   logic signed [BASE_W-1:0]         bx0_ff, by0_ff, bx1_ff, by1_ff, bx2_ff, by2_ff;
   // product stage 1
   logic signed [NUM_W-1:0]          t1_ff, t3_ff;
   logic [NUM_W-1:0]                 u2_ff, u4_ff;
   // product stage 2: numerators of the four coordinates
   logic signed [NUM_W-1:0]          nax_ff, nay_ff, nbx_ff, nby_ff;

   always_comb begin
      r_sel = sq_geo.tan ? '0 : sq_root;
      if (!sq_geo.ok) begin
         cnt_in = COUNT_NONE;
      end else if (sq_geo.tan) begin
         cnt_in = COUNT_ONE;
      end else begin
         cnt_in = COUNT_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (advance) begin
         p0_valid_ff <= sq_valid;
         p1_valid_ff <= p0_valid_ff;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pxh_ff    <= $signed(sq_geo.dx) * $signed(sq_geo.k[K_W-1:KL_W]);
         pxl_ff    <= $signed(sq_geo.dx) * $signed({1'b0, sq_geo.k[KL_W-1:0]});
         pyh_ff    <= $signed(sq_geo.dy) * $signed(sq_geo.k[K_W-1:KL_W]);
         pyl_ff    <= $signed(sq_geo.dy) * $signed({1'b0, sq_geo.k[KL_W-1:0]});
         a2h_ff    <= sq_geo.ady * r_sel[ROOT_W-1:HALF_W];
         a2l_ff    <= sq_geo.ady * r_sel[HALF_W-1:0];
         a4h_ff    <= sq_geo.adx * r_sel[ROOT_W-1:HALF_W];
         a4l_ff    <= sq_geo.adx * r_sel[HALF_W-1:0];
         // sign of (s * dx) * r, with s the sign of dy
         s4neg0_ff <= sq_geo.dx[DXN_W-1] ^ sq_geo.dy[DXN_W-1];
         cnt0_ff   <= cnt_in;
         d2_0_ff   <= sq_geo.d2;
         bx0_ff    <= sq_geo.bx;
         by0_ff    <= sq_geo.by;

         t1_ff     <= (NUM_W'(pxh_ff) <<< KL_W) + NUM_W'(pxl_ff);
         t3_ff     <= (NUM_W'(pyh_ff) <<< KL_W) + NUM_W'(pyl_ff);
         u2_ff     <= (NUM_W'(a2h_ff) << HALF_W) + NUM_W'(a2l_ff);
         u4_ff     <= (NUM_W'(a4h_ff) << HALF_W) + NUM_W'(a4l_ff);
         s4neg1_ff <= s4neg0_ff;
         cnt1_ff   <= cnt0_ff;
         d2_1_ff   <= d2_0_ff;
         bx1_ff    <= bx0_ff;
         by1_ff    <= by0_ff;

         nax_ff    <= t1_ff - $signed(u2_ff);
         nbx_ff    <= t1_ff + $signed(u2_ff);
         nay_ff    <= s4neg1_ff ? t3_ff - $signed(u4_ff) : t3_ff + $signed(u4_ff);
         nby_ff    <= s4neg1_ff ? t3_ff + $signed(u4_ff) : t3_ff - $signed(u4_ff);
         cnt2_ff   <= cnt1_ff;
         d2_2_ff   <= d2_1_ff;
         bx2_ff    <= bx1_ff;
         by2_ff    <= by1_ff;
      end
   end

   // four divider lanes; lane a_x carries the valid bit and count to the output
   logic      ax_valid;
   count_type ax_tag;

   tlik_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_ax (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (p2_valid_ff),
      .num       (nax_ff),
      .d2        (d2_2_ff),
      .base      (COORD_WIDTH'(bx2_ff)),
      .tag_in    (cnt2_ff),
      .out_valid (ax_valid),
      .coord     (rsp_if.elbow_a_x),
      .tag_out   (ax_tag)
   );

   tlik_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_ay (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (p2_valid_ff),
      .num       (nay_ff),
      .d2        (d2_2_ff),
      .base      (COORD_WIDTH'(by2_ff)),
      .tag_in    (cnt2_ff),
      .out_valid (),
      .coord     (rsp_if.elbow_a_y),
      .tag_out   ()
   );

   tlik_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_bx (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (p2_valid_ff),
      .num       (nbx_ff),
      .d2        (d2_2_ff),
      .base      (COORD_WIDTH'(bx2_ff)),
      .tag_in    (cnt2_ff),
      .out_valid (),
      .coord     (rsp_if.elbow_b_x),
      .tag_out   ()
   );

   tlik_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_by (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (p2_valid_ff),
      .num       (nby_ff),
      .d2        (d2_2_ff),
      .base      (COORD_WIDTH'(by2_ff)),
      .tag_in    (cnt2_ff),
      .out_valid (),
      .coord     (rsp_if.elbow_b_y),
      .tag_out   ()
   );

   assign rsp_if.valid          = ax_valid;
   assign rsp_if.solution_count = ax_tag;

endmodule
